### hw/rtl/dft_pkg.sv
// Shared types and constants for the DALI forward frame transmitter.
package dft_pkg;

  // Width of the command field as it arrives on the input channel.
  localparam int unsigned CMD_W = 16;

  // Default number of data bits in one forward frame.
  localparam int unsigned DATA_BITS_DEFAULT = 16;

  // Number of stop ticks after the last data half-bit.
  localparam int unsigned STOP_TICKS = 5;

  // Item kinds on the input channel.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [CMD_W-1:0] command;
  } in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } out_t;

endpackage

### hw/rtl/dft_in_stage.sv
// Input register stage of the DALI forward frame transmitter.
module dft_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dft_pkg::in_t  in_payload,
  output logic          item_valid,
  output dft_pkg::in_t  item,
  input  logic          item_take
);

  logic         valid_r;
  logic         valid_nxt;
  dft_pkg::in_t data_r;

  // The stage is free when empty or when its item moves on this cycle.
  assign in_ready   = !valid_r || item_take;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !item_take);
  assign item_valid = valid_r;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_payload;
    end
  end

endmodule

### hw/rtl/dft_tx_core.sv
// Frame state, Manchester encoder and result register of the transmitter.
module dft_tx_core #(
  parameter int unsigned DATA_BITS = dft_pkg::DATA_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          item_valid,
  input  dft_pkg::in_t  item,
  output logic          item_take,
  output logic          out_valid,
  input  logic          out_ready,
  output dft_pkg::out_t out_payload
);

  localparam int unsigned ENC_W = 2 * DATA_BITS;
  localparam int unsigned CNT_W = $clog2(ENC_W);

  typedef enum logic [1:0] {
    PH_START,
    PH_DATA,
    PH_STOP
  } phase_t;

  phase_t             phase_r;
  phase_t             phase_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [ENC_W-1:0]   enc_r;
  logic [ENC_W-1:0]   enc_nxt;
  logic [ENC_W-1:0]   enc_cmd;
  logic               running_r;
  logic               running_nxt;
  logic               line_r;
  logic               line_nxt;
  logic               done_nxt;
  logic               idle_level_r;
  logic               out_valid_r;
  dft_pkg::out_t      out_r;

  // Each of the first DATA_BITS command bits becomes a pair of half-bits; data bits beyond
  // the command field count as zeros.
  for (genvar i = 0; i < DATA_BITS; i++) begin : g_enc
    if (i < dft_pkg::CMD_W) begin : g_cmd
      assign enc_cmd[2*i]   = item.command[i];
      assign enc_cmd[2*i+1] = ~item.command[i];
    end else begin : g_zero
      assign enc_cmd[2*i]   = 1'b0;
      assign enc_cmd[2*i+1] = 1'b1;
    end
  end

  assign item_take = item_valid && (!out_valid_r || out_ready);

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    enc_nxt     = enc_r;
    running_nxt = running_r;
    line_nxt    = line_r;
    done_nxt    = 1'b0;
    if (item.kind == dft_pkg::KIND_LOAD) begin
      enc_nxt = enc_cmd;
      if (!running_r) begin
        running_nxt = 1'b1;
        phase_nxt   = PH_START;
        count_nxt   = '0;
      end
    end else if (!running_r) begin
      line_nxt = idle_level_r;
    end else begin
      case (phase_r)
        PH_START: begin
          if (count_r == '0) begin
            line_nxt  = 1'b1;
            count_nxt = CNT_W'(1);
          end else begin
            line_nxt  = 1'b0;
            phase_nxt = PH_DATA;
            count_nxt = CNT_W'(ENC_W - 1);
          end
        end
        PH_DATA: begin
          line_nxt = enc_r[count_r];
          if (count_r == '0) begin
            phase_nxt = PH_STOP;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          line_nxt = idle_level_r;
          if (count_r >= CNT_W'(dft_pkg::STOP_TICKS - 1)) begin
            running_nxt = 1'b0;
            phase_nxt   = PH_START;
            count_nxt   = '0;
            done_nxt    = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      count_r      <= '0;
      enc_r        <= '0;
      running_r    <= 1'b0;
      line_r       <= 1'b0;
      idle_level_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        idle_level_r <= cfg_wr_data;
      end
      if (item_take) begin
        phase_r   <= phase_nxt;
        count_r   <= count_nxt;
        enc_r     <= enc_nxt;
        running_r <= running_nxt;
        line_r    <= line_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_r.line_level <= line_nxt;
      out_r.busy_res   <= running_nxt;
      out_r.frame_done <= done_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

### hw/rtl/dali_forward_frame_transmitter.sv
// Top level of the DALI forward frame transmitter.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   dft_pkg::in_t  (kind, command)
//   out_     output     out_valid / out_ready dft_pkg::out_t (line_level, busy_res,
//                                                              frame_done)
//   cfg_     input      cfg_wr_en             cfg_wr_data    (idle_level)
//
// A transaction accepted into the input register passes through the frame logic into the
// result register once the result register is free or its result is being taken, and
// its result is then shown on out_valid / out_payload until it is taken.
// One transaction is accepted per cycle while results are taken.
// The reset is synchronous and active low; it empties both registers, puts the
// frame back to the start bit phase and sets the idle level to low.
// When out_ready is held low the result stays in the result register, the
// next transaction waits in the input register and in_ready falls after that.
module dali_forward_frame_transmitter #(
  parameter int unsigned DATA_BITS = dft_pkg::DATA_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  dft_pkg::in_t  in_payload,
  output logic          out_valid,
  input  logic          out_ready,
  output dft_pkg::out_t out_payload
);

  // Transaction held in the input register, offered to the frame logic.
  logic         item_valid;
  logic         item_take;
  dft_pkg::in_t item;

  // The input register decouples the input handshake from the result side,
  // so a new transaction can enter while the previous result still waits.
  dft_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // The frame logic updates the frame state exactly once per transaction,
  // at the moment that transaction moves into the result register, so the
  // order of results always follows the order of transactions.
  dft_tx_core #(
    .DATA_BITS (DATA_BITS)
  ) u_tx_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

endmodule

### hw/rtl/dft_checker.sv
// Port level checks for the DALI forward frame transmitter, bound to the top level.
module dft_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input dft_pkg::out_t out_payload
);

  // A result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed or vanished");

  // A frame end always leaves the transmitter idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.frame_done |-> !out_payload.busy_res)
    else $error("frame end reported while still busy");

  // While results are being taken the input side never stalls.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled although the result side is free");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind dali_forward_frame_transmitter dft_checker u_dft_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_payload (out_payload)
);
